[hw/rtl/zsrle_pkg.sv]
`default_nettype none

package zsrle_pkg;

  localparam int MAX_HEIGHT = 1024;

  localparam int HEIGHT_W = 11;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 10;
  localparam int REP_W    = 9;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(200);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = BYTE_W + ROW_W + REP_W;

  // one decoded row as it waits in the queue
  typedef struct packed {
    logic              strip_end;
    logic [REP_W-1:0]  repeat_rows;
    logic [ROW_W-1:0]  first_row;
    logic [BYTE_W-1:0] row_bits;
  } zsrle_row_t;

  typedef struct packed {
    logic       push;
    zsrle_row_t row;
  } zsrle_push_t;

  function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
    logic [HEIGHT_W-1:0] r;
    r = h;
    if (h == '0) r = HEIGHT_W'(1);
    else if (h > HEIGHT_MAX) r = HEIGHT_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/zplane_strip_rle_decoder.sv]
`default_nettype none

// Z-plane strip RLE decoder. Takes one compressed byte per cycle on in_*, and for each
// row byte (not header bytes) emits one row transaction on out_*: the eight mask bits,
// the strip row it starts at, its repeat count (1..256, run rows are not expanded) and
// tlast on the row that completes the strip. Throughput is one byte per cycle while
// in_tready is high; rows reach out_* through the queue. The decode state sits in the
// front stage, which writes finished rows into a two-entry queue whose head drives
// out_*, so in_tready only drops while both queue entries are held by a stalled sink.
// cfg_* sets the strip height (0 acts as 1, above 1024 acts as 1024) and restarts the
// strip; write it only while the decoder is idle. Height after reset is 200.
module zplane_strip_rle_decoder
  import zsrle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] code_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [7:0] row_bits, [17:8] first_row,
                                                  // [26:18] repeat_rows, rest zero
  output logic                        out_tlast,  // strip_end
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [HEIGHT_W-1:0]    cfg_data
);

  zsrle_push_t push;
  zsrle_row_t  head;
  logic        full;
  logic        head_valid;

  assign in_tready = !full;
  assign cfg_ready = 1'b1;

  zsrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid),
    .cfg_height (cfg_data),
    .byte_acc   (in_tvalid && !full),
    .code_byte  (in_tdata),
    .push_o     (push)
  );

  zsrle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), head.repeat_rows, head.first_row,
                       head.row_bits};
  assign out_tlast  = head.strip_end;

endmodule

`default_nettype wire

[hw/rtl/zsrle_front.sv]
`default_nettype none

module zsrle_front
  import zsrle_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr,
  input  wire logic [HEIGHT_W-1:0] cfg_height,
  input  wire logic                byte_acc,
  input  wire logic [BYTE_W-1:0]   code_byte,
  output zsrle_push_t              push_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic [1:0]          phase_r, phase_nxt;
  logic [REP_W-1:0]    count_r, count_nxt;
  logic [HEIGHT_W-1:0] rows_r, rows_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;

  logic [REP_W-1:0]    n_req;
  logic [HEIGHT_W-1:0] n_clip;
  logic [HEIGHT_W-1:0] rows_after;
  logic [HEIGHT_W-1:0] first_full;
  logic [REP_W-1:0]    hdr_count;
  logic                done;

  always_comb begin
    n_req      = (phase_r == PH_RUN) ? count_r : REP_W'(1);
    n_clip     = ({2'b00, n_req} > rows_r) ? rows_r : {2'b00, n_req};
    rows_after = rows_r - n_clip;
    done       = (rows_after == '0);
    first_full = height_r - rows_r;
    // count of zero stands for 256
    hdr_count  = (code_byte[6:0] == 7'd0) ? REP_W'(256) : {2'b00, code_byte[6:0]};
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    rows_nxt   = rows_r;
    height_nxt = height_r;
    push_o.push             = 1'b0;
    push_o.row.row_bits     = code_byte;
    push_o.row.first_row    = first_full[ROW_W-1:0];
    push_o.row.repeat_rows  = n_clip[REP_W-1:0];
    push_o.row.strip_end    = done;

    if (cfg_wr) begin
      height_nxt = eff_height(cfg_height);
      phase_nxt  = PH_HEADER;
      count_nxt  = '0;
      rows_nxt   = eff_height(cfg_height);
    end else if (byte_acc) begin
      unique case (phase_r)
        PH_RUN, PH_LITERAL: begin
          push_o.push = 1'b1;
          rows_nxt    = rows_after;
          if (phase_r == PH_RUN) begin
            phase_nxt = PH_HEADER;
            count_nxt = '0;
          end else begin
            count_nxt = count_r - REP_W'(1);
            if (count_r == REP_W'(1)) phase_nxt = PH_HEADER;
          end
          if (done) begin
            phase_nxt = PH_HEADER;
            count_nxt = '0;
            rows_nxt  = height_r;
          end
        end
        default: begin
          count_nxt = hdr_count;
          phase_nxt = code_byte[7] ? PH_RUN : PH_LITERAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      count_r  <= '0;
      rows_r   <= HEIGHT_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      rows_r   <= rows_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zsrle_queue.sv]
`default_nettype none

module zsrle_queue
  import zsrle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire zsrle_push_t push_i,
  output logic       full,
  output logic       head_valid,
  output zsrle_row_t head,
  input  wire logic  pop
);

  zsrle_row_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_i.push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push_i.push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zsrle_checker.sv]
`default_nettype none

module zsrle_checker
  import zsrle_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[26:18] != 9'd0) && (out_tdata[26:18] <= 9'd256))
    else $error("repeat_rows out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("tdata padding not zero");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind zplane_strip_rle_decoder zsrle_checker u_zsrle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
